/* src/xcfr_pkg.sv */
// Shared types and constants for the XOR-checked frame receiver.
package xcfr_pkg;

  // Default largest frame, header included
  localparam int MAX_FRAME_DEF = 1024;

  // Frame start marker
  localparam logic [7:0] ID_BYTE = 8'hFF;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_ID   = 2'd1,
    ST_BAD_SUM  = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_t;

  // Parser phase, one-hot
  typedef enum logic [4:0] {
    PH_HUNT = 5'b00001,
    PH_SUM  = 5'b00010,
    PH_LENH = 5'b00100,
    PH_LENL = 5'b01000,
    PH_DATA = 5'b10000
  } phase_t;

  // One result from the parser
  typedef struct packed {
    logic       emit;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       frame_end;
    status_t    status;
  } result_t;

endpackage

/* src/xcfr_parser.sv */
// Frame parser: header decode, length bound check, payload XOR and frame end.
module xcfr_parser
  import xcfr_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] byte_in,
  output result_t    res
);

  localparam int LEN_LIMIT = MAX_FRAME - 4;
  localparam int CW        = $clog2(LEN_LIMIT + 1);

  phase_t          phase, phase_next;
  logic [7:0]      expected_sum, expected_sum_next;
  logic [7:0]      length_high, length_high_next;
  logic [CW-1:0]   bytes_left, bytes_left_next;
  logic [7:0]      running_xor, running_xor_next;

  logic [16:0]     len;
  logic            too_long;
  logic [CW-1:0]   left_dec;
  logic [7:0]      xor_now;

  assign len      = {1'b0, length_high, byte_in};
  assign too_long = 32'(len) > LEN_LIMIT;
  assign left_dec = (bytes_left != '0) ? bytes_left - CW'(1) : bytes_left;
  assign xor_now  = running_xor ^ byte_in;

  // Next state and result for the byte in hand
  always_comb begin
    phase_next        = phase;
    expected_sum_next = expected_sum;
    length_high_next  = length_high;
    bytes_left_next   = bytes_left;
    running_xor_next  = running_xor;
    res               = '{emit: 1'b0, data_valid: 1'b0, data_byte: 8'h00,
                          frame_end: 1'b0, status: ST_OK};
    unique case (phase)
      PH_SUM: begin
        expected_sum_next = byte_in;
        phase_next        = PH_LENH;
      end
      PH_LENH: begin
        length_high_next = byte_in;
        phase_next       = PH_LENL;
      end
      PH_LENL: begin
        if (too_long) begin
          phase_next    = PH_HUNT;
          res.emit      = 1'b1;
          res.frame_end = 1'b1;
          res.status    = ST_TOO_LONG;
        end else if (len == 17'd0) begin
          phase_next    = PH_HUNT;
          res.emit      = 1'b1;
          res.frame_end = 1'b1;
          res.status    = (expected_sum == 8'h00) ? ST_OK : ST_BAD_SUM;
        end else begin
          bytes_left_next  = CW'(len);
          running_xor_next = 8'h00;
          phase_next       = PH_DATA;
        end
      end
      PH_DATA: begin
        running_xor_next = xor_now;
        bytes_left_next  = left_dec;
        res.emit         = 1'b1;
        res.data_valid   = 1'b1;
        res.data_byte    = byte_in;
        if (left_dec == '0) begin
          phase_next    = PH_HUNT;
          res.frame_end = 1'b1;
          res.status    = (xor_now == expected_sum) ? ST_OK : ST_BAD_SUM;
        end
      end
      default: begin
        // hunting; stray codes behave the same
        if (byte_in == ID_BYTE) begin
          phase_next = PH_SUM;
        end else begin
          phase_next    = PH_HUNT;
          res.emit      = 1'b1;
          res.frame_end = 1'b1;
          res.status    = ST_BAD_ID;
        end
      end
    endcase
  end

  // State registers, advanced only when the byte is consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      expected_sum <= 8'h00;
      length_high  <= 8'h00;
      bytes_left   <= '0;
      running_xor  <= 8'h00;
    end else if (fire) begin
      phase        <= phase_next;
      expected_sum <= expected_sum_next;
      length_high  <= length_high_next;
      bytes_left   <= bytes_left_next;
      running_xor  <= running_xor_next;
    end
  end

endmodule

/* src/xor_checked_frame_receiver.sv */
// Top level of the XOR-checked frame receiver: input register, parser, result register.
//
//   channel  direction  handshake            payload
//   in       receive    in_valid / in_stall  rx_byte
//   out      send       out_valid/out_stall  data_valid, data_byte, frame_end, status
//
// One byte per cycle sustained while out_stall is low; a byte passes the input register,
// then the parser into the result register.
// Header bytes, but for a length byte that ends the frame, give no result and never wait on the output side.
// Reset (rst, synchronous) empties both registers and returns the parser to hunting.
// A stalled result holds; the input register keeps one byte waiting behind it.
module xor_checked_frame_receiver
  import xcfr_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       data_valid,
  output logic [7:0] data_byte,
  output logic       frame_end,
  output logic [1:0] status
);

  logic       in_full;
  logic [7:0] in_byte;
  logic       consume;
  result_t    res;
  result_t    out_res;

  xcfr_parser #(
    .MAX_FRAME (MAX_FRAME)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .fire    (consume),
    .byte_in (in_byte),
    .res     (res)
  );

  // Consume the held byte unless its result would land on a stalled one
  assign consume  = in_full && (!res.emit || !out_valid || !out_stall);
  assign in_stall = in_full && !consume;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (consume) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= rx_byte;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (consume && res.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && res.emit) begin
      out_res <= res;
    end
  end

  assign data_valid = out_res.data_valid;
  assign data_byte  = out_res.data_byte;
  assign frame_end  = out_res.frame_end;
  assign status     = out_res.status;

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !(consume && res.emit))
    else $error("result register overwritten while stalled");

  // A byte held back stays held
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> in_full && $stable(in_byte))
    else $error("held input byte lost");

  // Without payload the byte field is zero and the result ends a frame
  a_blank_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !data_valid) |-> (data_byte == 8'h00 && frame_end))
    else $error("non-payload result malformed");

  // Mid-frame results are plain payload bytes
  a_mid_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !frame_end) |-> (data_valid && status == ST_OK))
    else $error("mid-frame result carries a status");

  // Error codes for id and length never come with payload
  a_err_no_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_BAD_ID || status == ST_TOO_LONG)) |-> !data_valid)
    else $error("header error carries payload");

endmodule

/* verif/testbench.sv */
// Testbench for the XOR-checked frame receiver: directed and random byte streams, scoreboard.
module testbench;
  import xcfr_pkg::*;

  localparam int LEN_LIMIT     = MAX_FRAME_DEF - 4;
  localparam int LEFT_W        = $clog2(LEN_LIMIT + 1);
  localparam int LONG_HOLD     = 200;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int MAX_REPORTS   = 10;

  // One result as seen on the output port
  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic       frame_end;
    status_t    status;
  } frame_result_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       data_valid;
  logic [7:0] data_byte;
  logic       frame_end;
  logic [1:0] status;

  xor_checked_frame_receiver uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .data_valid (data_valid),
    .data_byte  (data_byte),
    .frame_end  (frame_end),
    .status     (status)
  );

  // Clock, period 10
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run control
  int  cycle_count = 0;
  int  error_count = 0;
  int  bytes_sent = 0;
  bit  sender_idles = 1'b1;
  bit  receiver_idles = 1'b1;
  bit  long_hold_request = 1'b0;

  // Expected results, oldest first
  frame_result_t pending_results [$];

  // Deframer state mirrored from the block
  phase_t            parse_phase = PH_HUNT;
  logic [7:0]        frame_sum = 8'h00;
  logic [7:0]        len_high = 8'h00;
  logic [LEFT_W-1:0] payload_left = '0;
  logic [7:0]        payload_xor = 8'h00;

  // Advance the deframer by one accepted byte and queue any result it gives
  function automatic void parse_byte(input logic [7:0] b);
    logic [15:0]   len;
    frame_result_t r;
    r = '{data_valid: 1'b0, data_byte: 8'h00, frame_end: 1'b1, status: ST_OK};
    case (parse_phase)
      PH_SUM: begin
        frame_sum   = b;
        parse_phase = PH_LENH;
      end
      PH_LENH: begin
        len_high    = b;
        parse_phase = PH_LENL;
      end
      PH_LENL: begin
        len = {len_high, b};
        if (len > LEN_LIMIT) begin
          parse_phase = PH_HUNT;
          r.status    = ST_TOO_LONG;
          pending_results.push_back(r);
        end else if (len == 16'd0) begin
          parse_phase = PH_HUNT;
          if (frame_sum == 8'h00) r.status = ST_OK;
          else r.status = ST_BAD_SUM;
          pending_results.push_back(r);
        end else begin
          payload_left = len[LEFT_W-1:0];
          payload_xor  = 8'h00;
          parse_phase  = PH_DATA;
        end
      end
      PH_DATA: begin
        payload_xor = payload_xor ^ b;
        if (payload_left != '0) payload_left = payload_left - LEFT_W'(1);
        r.data_valid = 1'b1;
        r.data_byte  = b;
        if (payload_left == '0) begin
          parse_phase = PH_HUNT;
          if (payload_xor == frame_sum) r.status = ST_OK;
          else r.status = ST_BAD_SUM;
        end else begin
          r.frame_end = 1'b0;
          r.status    = ST_OK;
        end
        pending_results.push_back(r);
      end
      default: begin
        if (b == ID_BYTE) begin
          parse_phase = PH_SUM;
        end else begin
          parse_phase = PH_HUNT;
          r.status    = ST_BAD_ID;
          pending_results.push_back(r);
        end
      end
    endcase
  endfunction

  // Offer one byte, with an occasional idle burst first; predict on acceptance
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (sender_idles && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    parse_byte(b);
    bytes_sent++;
  endtask

  // Header plus random payload; a too-long length sends the header only
  task automatic send_frame(input int len, input bit sum_ok);
    logic [7:0]  body [$];
    logic [7:0]  sum;
    logic [7:0]  b;
    logic [15:0] len16;
    len16 = len[15:0];
    sum   = 8'h00;
    if (len <= LEN_LIMIT) begin
      for (int i = 0; i < len; i++) begin
        b = 8'($urandom_range(0, 255));
        body.push_back(b);
        sum = sum ^ b;
      end
    end
    if (!sum_ok) begin
      b   = 8'($urandom_range(1, 255));
      sum = sum ^ b;
    end
    send_byte(ID_BYTE);
    send_byte(sum);
    send_byte(len16[15:8]);
    send_byte(len16[7:0]);
    foreach (body[i]) send_byte(body[i]);
  endtask

  // Sender rests until every expected result has come back
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Wrong id bytes, empty frames, the length bound, short good and bad frames
  task automatic test_directed_cases();
    logic [7:0] seq [25];
    seq = '{8'h00, 8'hFE,
            ID_BYTE, 8'h00, 8'h00, 8'h00,
            ID_BYTE, 8'h5A, 8'h00, 8'h00,
            ID_BYTE, 8'h00, 8'h03, 8'hFD,
            ID_BYTE, 8'hA5, 8'h00, 8'h01, 8'hA5,
            ID_BYTE, 8'h00, 8'h00, 8'h02, 8'h01, 8'h02};
    foreach (seq[i]) send_byte(seq[i]);
    wait_for_results();
  endtask

  // Longest legal frame while the receiver holds off, so the block backs up
  task automatic test_full_backpressure();
    long_hold_request = 1'b1;
    send_frame(LEN_LIMIT, 1'b1);
    wait_for_results();
  endtask

  // Mostly well-formed frames of random content, with broken headers and noise
  task automatic test_random_stream(input int n_items);
    int start;
    int pick;
    int len;
    int n;
    start = bytes_sent;
    while (bytes_sent - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        case ($urandom_range(0, 9))
          0:       len = 0;
          1:       len = $urandom_range(17, 80);
          default: len = $urandom_range(1, 16);
        endcase
        send_frame(len, $urandom_range(0, 3) != 0);
      end else if (pick < 85) begin
        send_frame($urandom_range(LEN_LIMIT + 1, 65535), 1'b1);
      end else if (pick < 90) begin
        // header cut short, whatever follows is parsed as header
        send_byte(ID_BYTE);
        n = $urandom_range(0, 2);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Closing stretch at full rate on both sides
  task automatic test_steady_stream();
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    test_random_stream(250);
  endtask

  // Receiver: random stall bursts, and a long hold on request
  initial begin : result_receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold_request) begin
        long_hold_request = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && receiver_idles && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 19);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    frame_result_t got;
    frame_result_t want;
    if (rst === 1'b0 && out_valid === 1'b1 && out_stall === 1'b0) begin
      got.data_valid = data_valid;
      got.data_byte  = data_byte;
      got.frame_end  = frame_end;
      got.status     = status_t'(status);
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected result: valid=%0b byte=%02h end=%0b status=%0d",
                   got.data_valid, got.data_byte, got.frame_end, got.status);
      end else begin
        want = pending_results.pop_front();
        if (got.data_valid !== want.data_valid || got.data_byte !== want.data_byte ||
            got.frame_end !== want.frame_end || got.status !== want.status) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display({"mismatch: expected valid=%0b byte=%02h end=%0b status=%0d, ",
                      "got valid=%0b byte=%02h end=%0b status=%0d"},
                     want.data_valid, want.data_byte, want.frame_end, want.status,
                     got.data_valid, got.data_byte, got.frame_end, got.status);
        end
      end
    end
  end

  // Cycle counter and watchdog
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("testbench: done, errors");
    $finish;
  end

  // Test sequence
  initial begin : stimulus
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_full_backpressure();
    test_random_stream(300);
    test_steady_stream();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
src/xcfr_pkg.sv
src/xcfr_parser.sv
src/xor_checked_frame_receiver.sv
verif/testbench.sv
